@@ rtl/prp_pkg.sv @@
// Package: shared constants and types for the page replacement policy block.
`timescale 1ns / 1ps
package prp_pkg;
  localparam int unsigned MaxFrames = 8;
  localparam int unsigned PageBits  = 8;
  localparam int unsigned CountBits = 16;

  typedef enum logic [2:0] {
    PolFifo   = 3'd0,
    PolLru    = 3'd1,
    PolLfu    = 3'd2,
    PolMfuFifo = 3'd3,
    PolMfuLru = 3'd4
  } policy_e;

  localparam logic CfgPolicy = 1'b0;
  localparam logic CfgFrames = 1'b1;
endpackage

@@ rtl/prp_front.sv @@
// Front part: accepts page references and holds them in a short queue.
`timescale 1ns / 1ps
module prp_front #(
  parameter int unsigned PageBitsP = prp_pkg::PageBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 flush_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           page_i,
  output logic                 q_valid_o,
  input  logic                 q_ready_i,
  output logic [PageBitsP-1:0] q_page_o
);
  import prp_pkg::*;

  logic [PageBitsP-1:0] buf_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q;
  logic       push, pop;
  logic [PageBitsP-1:0] pg;

  // Keep only the low page bits.
  always_comb begin
    pg = '0;
    for (int b = 0; b < PageBitsP; b++) begin
      if (b < 8) pg[b] = page_i[b];
    end
  end

  assign in_ready_o = (cnt_q != 2'd2) && !flush_i;
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop = q_valid_o && q_ready_i;
  assign q_page_o = buf_q[rp_q];
  assign cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};

  // Advance the two-entry queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= pg;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2)
    else $error("full queue lost an item");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !pop)
    else $error("pop from empty queue");
endmodule

@@ rtl/prp_back.sv @@
// Back part: updates the frame list for one reference and streams the frames out.
`timescale 1ns / 1ps
module prp_back #(
  parameter int unsigned MaxFramesP = prp_pkg::MaxFrames,
  parameter int unsigned PageBitsP  = prp_pkg::PageBits,
  parameter int unsigned CountBitsP = prp_pkg::CountBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clear_i,
  input  logic [2:0]           policy_i,
  input  logic [3:0]           frames_i,
  input  logic                 q_valid_i,
  output logic                 q_ready_o,
  input  logic [PageBitsP-1:0] q_page_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           frame_page_o,
  output logic [2:0]           position_o,
  output logic                 was_fault_o,
  output logic                 was_replaced_o,
  output logic [31:0]          fault_total_o,
  output logic [31:0]          replace_total_o,
  output logic                 last_o
);
  import prp_pkg::*;

  localparam int unsigned IdxW = (MaxFramesP > 1) ? $clog2(MaxFramesP) : 1;
  localparam int unsigned OccW = $clog2(MaxFramesP + 1);
  localparam logic [CountBitsP-1:0] CntMax = '1;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StScan = 4'b0010,
    StMove = 4'b0100,
    StEmit = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [PageBitsP-1:0]  pages_q [MaxFramesP];
  logic [CountBitsP-1:0] cnts_q  [MaxFramesP];
  logic [OccW-1:0] occ_q;
  logic [31:0] faults_q, repl_q;
  logic [PageBitsP-1:0] pg_q;
  logic [IdxW-1:0] idx_q, best_q, hit_idx_q;
  logic [OccW-1:0] emit_q;
  logic hit_q, fault_q, repl_flag_q;
  policy_e pol;
  logic [OccW-1:0] lim;
  logic [CountBitsP-1:0] carry_cnt;
  logic [IdxW-1:0] drop_idx;
  logic do_drop;

  // Resolve policy and frame limit.
  always_comb begin
    pol = PolFifo;
    case (policy_i)
      PolLru:     pol = PolLru;
      PolLfu:     pol = PolLfu;
      PolMfuFifo: pol = PolMfuFifo;
      PolMfuLru:  pol = PolMfuLru;
      default:    pol = PolFifo;
    endcase
    if (frames_i == 4'd0) lim = OccW'(1);
    else if (32'(frames_i) > MaxFramesP) lim = OccW'(MaxFramesP);
    else lim = OccW'(frames_i);
  end

  assign q_ready_o = (state_q == StIdle) && !clear_i;

  // Choose the entry to drop and the count to append.
  always_comb begin
    do_drop = 1'b0;
    drop_idx = best_q;
    carry_cnt = CountBitsP'(1);
    if (hit_q) begin
      drop_idx = hit_idx_q;
      carry_cnt = cnts_q[hit_idx_q];
      if (pol != PolLru && carry_cnt != CntMax) carry_cnt = carry_cnt + 1'b1;
      do_drop = (pol == PolLru) || (pol == PolLfu) || (pol == PolMfuLru);
    end else begin
      do_drop = (occ_q >= lim);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (q_valid_i && q_ready_o) state_d = StScan;
      StScan: if ((OccW'(idx_q) + 1'b1 >= occ_q) || hit_q) state_d = StMove;
      StMove: state_d = StEmit;
      StEmit: if (out_ready_i && emit_q == OccW'(1)) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      occ_q <= '0;
      faults_q <= '0;
      repl_q <= '0;
    end else if (clear_i) begin
      state_q <= StIdle;
      occ_q <= '0;
      faults_q <= '0;
      repl_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StMove) begin
        if (!hit_q) begin
          if (faults_q != '1) faults_q <= faults_q + 1'b1;
          if (do_drop && repl_q != '1) repl_q <= repl_q + 1'b1;
          if (!do_drop) occ_q <= occ_q + 1'b1;
        end
      end
    end
  end

  // Scan one entry per cycle for a hit and the victim.
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        pg_q <= q_page_i;
        idx_q <= '0;
        best_q <= '0;
        hit_q <= 1'b0;
        hit_idx_q <= '0;
      end
      StScan: begin
        if (occ_q != '0 && !hit_q) begin
          if (pages_q[idx_q] == pg_q) begin
            hit_q <= 1'b1;
            hit_idx_q <= idx_q;
          end
          if (idx_q != '0) begin
            if (pol == PolLfu && cnts_q[idx_q] < cnts_q[best_q]) best_q <= idx_q;
            if ((pol == PolMfuFifo || pol == PolMfuLru) &&
                cnts_q[idx_q] > cnts_q[best_q]) best_q <= idx_q;
          end
        end
        if (OccW'(idx_q) + 1'b1 < occ_q && !hit_q) idx_q <= idx_q + 1'b1;
      end
      StMove: begin
        fault_q <= !hit_q;
        repl_flag_q <= !hit_q && do_drop;
        if (hit_q && pol == PolMfuFifo) begin
          cnts_q[hit_idx_q] <= carry_cnt;
        end else if (!hit_q || do_drop) begin
          for (int i = 0; i < MaxFramesP; i++) begin
            if (do_drop && IdxW'(i) >= drop_idx && OccW'(i) + 1'b1 < occ_q) begin
              pages_q[i] <= pages_q[(i + 1) % MaxFramesP];
              cnts_q[i]  <= cnts_q[(i + 1) % MaxFramesP];
            end
            if (OccW'(i) == (do_drop ? occ_q - 1'b1 : occ_q)) begin
              pages_q[i] <= pg_q;
              cnts_q[i]  <= carry_cnt;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Emit counter: newest first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) emit_q <= '0;
    else if (state_q == StMove) emit_q <= (!hit_q && !do_drop) ? occ_q + 1'b1 : occ_q;
    else if (state_q == StEmit && out_ready_i) emit_q <= emit_q - 1'b1;
  end

  logic [IdxW-1:0] src;
  logic [OccW-1:0] pos_full;
  assign src = IdxW'(emit_q - 1'b1);
  assign pos_full = occ_q - emit_q;
  assign out_valid_o = (state_q == StEmit);
  always_comb begin
    frame_page_o = '0;
    for (int b = 0; b < 8; b++) begin
      if (b < PageBitsP) frame_page_o[b] = pages_q[src][b];
    end
  end
  assign position_o = 3'(pos_full);
  assign was_fault_o = fault_q;
  assign was_replaced_o = repl_flag_q;
  assign fault_total_o = faults_q;
  assign replace_total_o = repl_q;
  assign last_o = (emit_q == OccW'(1));

  assert property (@(posedge clk_i) disable iff (!rst_ni) occ_q <= OccW'(MaxFramesP))
    else $error("occupancy above frame count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> emit_q != '0)
    else $error("emit with no frames");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit && !out_ready_i) |=> (state_q == StEmit && $stable(emit_q)))
    else $error("stalled result changed");
endmodule

@@ rtl/page_replacement_policy.sv @@
// The hit and victim scan walks one frame per cycle. A two-entry queue holds new
// references while the back part works on one; it takes the next after the last frame.
// Reset: frames empty, counters zero, policy fifo, three frames in use.
// A configuration write clears frames and counters.
`timescale 1ns / 1ps
module page_replacement_policy #(
  parameter int unsigned MaxFramesP = prp_pkg::MaxFrames,
  parameter int unsigned PageBitsP  = prp_pkg::PageBits,
  parameter int unsigned CountBitsP = prp_pkg::CountBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  page_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  frame_page_o,
  output logic [2:0]  position_o,
  output logic        was_fault_o,
  output logic        was_replaced_o,
  output logic [31:0] fault_total_o,
  output logic [31:0] replace_total_o,
  output logic        last_o
);
  import prp_pkg::*;

  logic [2:0] policy_q;
  logic [3:0] frames_q;
  logic clear;
  logic qv, qr;
  logic [PageBitsP-1:0] qp;

  assign cfg_ready_o = 1'b1;
  assign clear = cfg_valid_i;

  // Hold configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= PolFifo;
      frames_q <= 4'd3;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgPolicy) policy_q <= cfg_data_i[2:0];
      else frames_q <= cfg_data_i;
    end
  end

  prp_front #(.PageBitsP(PageBitsP)) u_front (
    .clk_i, .rst_ni, .flush_i(clear), .in_valid_i, .in_ready_o, .page_i,
    .q_valid_o(qv), .q_ready_i(qr), .q_page_o(qp)
  );

  prp_back #(.MaxFramesP(MaxFramesP), .PageBitsP(PageBitsP), .CountBitsP(CountBitsP)) u_back (
    .clk_i, .rst_ni, .clear_i(clear), .policy_i(policy_q), .frames_i(frames_q),
    .q_valid_i(qv), .q_ready_o(qr), .q_page_i(qp),
    .out_valid_o, .out_ready_i, .frame_page_o, .position_o, .was_fault_o,
    .was_replaced_o, .fault_total_o, .replace_total_o, .last_o
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_valid_i |-> !in_ready_o)
    else $error("item accepted during a register write");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> !out_valid_o)
    else $error("result after clear");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(frame_page_o) && $stable(position_o)))
    else $error("stalled result changed");
endmodule

@@ tb/page_replacement_policy_checker.sv @@
// Checker: predicts frame listings per page reference and compares results.
`timescale 1ns / 1ps
module page_replacement_policy_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  page_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  frame_page_i,
  input  logic [2:0]  position_i,
  input  logic        was_fault_i,
  input  logic        was_replaced_i,
  input  logic [31:0] fault_total_i,
  input  logic [31:0] replace_total_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);
  import prp_pkg::*;

  typedef struct packed {
    logic [7:0]  frame_page;
    logic [2:0]  position;
    logic        was_fault;
    logic        was_replaced;
    logic [31:0] fault_total;
    logic [31:0] replace_total;
    logic        last;
  } frame_line_t;

  localparam logic [CountBits-1:0] RefCountMax = '1;

  // Resident list, oldest at index zero
  logic [7:0]           res_page  [MaxFrames];
  logic [CountBits-1:0] res_count [MaxFrames];
  int unsigned          occupied;
  logic [31:0]          faults;
  logic [31:0]          replacements;
  logic [2:0]           policy_raw;
  logic [3:0]           frames_raw;
  frame_line_t          listing_q[$];
  int                   errors = 0;

  assign fail_count_o = errors;
  assign pending_o    = listing_q.size();

  task automatic flag_error(input string what, input logic [31:0] got,
                            input logic [31:0] want);
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  function automatic logic [CountBits-1:0] bump(input logic [CountBits-1:0] c);
    return (c == RefCountMax) ? c : c + 1'b1;
  endfunction

  // Remove entry at idx, closing the gap toward the oldest end
  task automatic remove_entry(input int unsigned idx);
    for (int unsigned i = idx; i + 1 < occupied; i++) begin
      res_page[i]  = res_page[i+1];
      res_count[i] = res_count[i+1];
    end
    occupied--;
  endtask

  task automatic add_newest(input logic [7:0] pg, input logic [CountBits-1:0] c);
    res_page[occupied]  = pg;
    res_count[occupied] = c;
    occupied++;
  endtask

  task automatic predict_reference(input logic [7:0] pg);
    policy_e       pol;
    int unsigned   lim;
    int unsigned   hit_idx;
    int unsigned   victim;
    logic          hit;
    logic          fault;
    logic          replaced;
    logic [CountBits-1:0] c;
    frame_line_t   line;
    pol = (policy_raw > PolMfuLru) ? PolFifo : policy_e'(policy_raw);
    lim = (frames_raw == 0) ? 1 : (frames_raw > MaxFrames) ? MaxFrames : frames_raw;
    hit = 1'b0;
    hit_idx = 0;
    fault = 1'b0;
    replaced = 1'b0;
    for (int unsigned i = 0; i < occupied; i++) begin
      if (!hit && res_page[i] == pg) begin
        hit = 1'b1;
        hit_idx = i;
      end
    end
    if (hit) begin
      if (pol == PolMfuFifo) begin
        res_count[hit_idx] = bump(res_count[hit_idx]);
      end else if (pol != PolFifo) begin
        c = res_count[hit_idx];
        if (pol != PolLru) c = bump(c);
        remove_entry(hit_idx);
        add_newest(pg, c);
      end
    end else begin
      fault = 1'b1;
      if (faults != '1) faults++;
      if (occupied >= lim) begin
        replaced = 1'b1;
        if (replacements != '1) replacements++;
        // Oldest wins ties: only a strictly better count moves the victim
        victim = 0;
        for (int unsigned i = 1; i < occupied; i++) begin
          if (pol == PolLfu && res_count[i] < res_count[victim]) victim = i;
          if ((pol == PolMfuFifo || pol == PolMfuLru) &&
              res_count[i] > res_count[victim]) victim = i;
        end
        remove_entry(victim);
      end
      add_newest(pg, CountBits'(1));
    end
    // Listing runs newest first
    for (int unsigned k = 0; k < occupied; k++) begin
      line.frame_page    = res_page[occupied-1-k];
      line.position      = k[2:0];
      line.was_fault     = fault;
      line.was_replaced  = replaced;
      line.fault_total   = faults;
      line.replace_total = replacements;
      line.last          = (k == occupied - 1);
      listing_q = {listing_q, line};
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_line_t want;
    if (!rst_ni) begin
      occupied     = 0;
      faults       = '0;
      replacements = '0;
      policy_raw   = PolFifo;
      frames_raw   = 4'd3;
      listing_q.delete();
    end else begin
      // Any register write empties the frames and clears the counters
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgPolicy) policy_raw = cfg_data_i[2:0];
        else frames_raw = cfg_data_i;
        occupied     = 0;
        faults       = '0;
        replacements = '0;
      end
      if (in_valid_i && in_ready_i) predict_reference(page_i);
      if (out_valid_i && out_ready_i) begin
        if (listing_q.size() == 0) begin
          flag_error("unexpected result, page", 32'(frame_page_i), 32'd0);
        end else begin
          want = listing_q.pop_front();
          if (frame_page_i !== want.frame_page)
            flag_error("frame_page", 32'(frame_page_i), 32'(want.frame_page));
          if (position_i !== want.position)
            flag_error("position", 32'(position_i), 32'(want.position));
          if (was_fault_i !== want.was_fault)
            flag_error("was_fault", 32'(was_fault_i), 32'(want.was_fault));
          if (was_replaced_i !== want.was_replaced)
            flag_error("was_replaced", 32'(was_replaced_i), 32'(want.was_replaced));
          if (fault_total_i !== want.fault_total)
            flag_error("fault_total", fault_total_i, want.fault_total);
          if (replace_total_i !== want.replace_total)
            flag_error("replace_total", replace_total_i, want.replace_total);
          if (last_i !== want.last)
            flag_error("last", 32'(last_i), 32'(want.last));
        end
      end
    end
  end
endmodule

@@ tb/page_replacement_policy_test.sv @@
// Testbench top: clock, reset, reference stimulus, configuration phases and verdict.
`timescale 1ns / 1ps
module page_replacement_policy_test;
  import prp_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 20;
  localparam int NumPhases = 12;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i;
  logic [3:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  page_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  frame_page_o;
  logic [2:0]  position_o;
  logic        was_fault_o;
  logic        was_replaced_o;
  logic [31:0] fault_total_o;
  logic [31:0] replace_total_o;
  logic        last_o;
  int          fail_count;
  int          pending;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic        long_hold_req;
  int          cycles = 0;

  always #2 clk_i = ~clk_i;

  page_replacement_policy dut (.*);

  page_replacement_policy_checker checker_i (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .page_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .frame_page_i(frame_page_o), .position_i(position_o),
    .was_fault_i(was_fault_o), .was_replaced_i(was_replaced_o),
    .fault_total_i(fault_total_o), .replace_total_i(replace_total_o),
    .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    int hold_left;
    bit hold_used;
    if (long_hold_req && !hold_used) begin
      hold_left = 300;
      hold_used = 1'b1;
    end
    if (hold_left > 0) begin
      out_ready_i = 1'b0;
      hold_left--;
    end else begin
      out_ready_i = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic wait_drained();
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic offer_page(input logic [7:0] pg);
    while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk_i);
    in_valid_i = 1'b1;
    page_i = pg;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Write only with the block idle: drained, then its scan latency allowed to pass
  task automatic write_register(input logic [0:0] idx, input logic [3:0] data);
    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [7:0] pick_page();
    // Mostly a small working set so hits and evictions are frequent
    if ($urandom_range(0, 99) < 75) return 8'($urandom_range(0, 11));
    return 8'($urandom_range(0, 255));
  endfunction

  logic [3:0] phase_policy [NumPhases];
  logic [3:0] phase_frames [NumPhases];

  initial begin
    // Policy codes 5 to 7 are undefined and must act as fifo; bit 3 of a
    // policy write is dropped. Frame limits 0 and above eight are clamped.
    phase_policy = '{4'(PolLru), 4'(PolLfu), {1'b1, PolMfuFifo}, 4'(PolMfuLru),
                     4'd5, 4'(PolLfu), 4'(PolMfuFifo), {1'b1, PolMfuLru},
                     4'(PolFifo), 4'd15, 4'(PolLru), 4'(PolMfuLru)};
    phase_frames = '{4'd1, 4'd8, 4'd4, 4'd8, 4'd2, 4'd0, 4'd15, 4'd9,
                     4'd8, 4'd5, 4'd3, 4'd6};
    long_hold_req = 1'b0;
    send_idle_pct = 16;
    recv_idle_pct = 46;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgPolicy;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    page_i = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed, reset settings (fifo, three frames): extremes, fill, evict, hit
    offer_page(8'h00);
    offer_page(8'hff);
    offer_page(8'h55);
    offer_page(8'haa);
    offer_page(8'hff);
    offer_page(8'h00);
    offer_page(8'h01);
    offer_page(8'h01);

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph == 4) begin
        send_idle_pct = 46;
        recv_idle_pct = 16;
      end else if (ph == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_register(CfgPolicy, phase_policy[ph]);
      write_register(CfgFrames, phase_frames[ph]);
      for (int n = 0; n < 20; n++) begin
        // Long receiver hold-off while the sender keeps pushing
        if (ph == 1 && n == 2) long_hold_req = 1'b1;
        // Sender pause until every listing has come out
        if (ph == 9 && n == 10) wait_drained();
        offer_page(pick_page());
      end
    end

    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
